// ===== hdl/r256_pkg.sv =====
// Package: RIPEMD-256 constants, step tables and shared types.
`default_nettype none
package r256_pkg;

    typedef logic [3:0] nib_t;

    typedef struct packed {
        logic [1:0]  fsel;   // boolean function select
        logic [3:0]  rot;    // left-rotate amount
        logic [31:0] kadd;   // round constant
    } step_ctrl_t;

    localparam nib_t SEL_L [64] = '{
        4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
        4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15,
        4'd7, 4'd4, 4'd13, 4'd1, 4'd10, 4'd6, 4'd15, 4'd3,
        4'd12, 4'd0, 4'd9, 4'd5, 4'd2, 4'd14, 4'd11, 4'd8,
        4'd3, 4'd10, 4'd14, 4'd4, 4'd9, 4'd15, 4'd8, 4'd1,
        4'd2, 4'd7, 4'd0, 4'd6, 4'd13, 4'd11, 4'd5, 4'd12,
        4'd1, 4'd9, 4'd11, 4'd10, 4'd0, 4'd8, 4'd12, 4'd4,
        4'd13, 4'd3, 4'd7, 4'd15, 4'd14, 4'd5, 4'd6, 4'd2};

    localparam nib_t SEL_R [64] = '{
        4'd5, 4'd14, 4'd7, 4'd0, 4'd9, 4'd2, 4'd11, 4'd4,
        4'd13, 4'd6, 4'd15, 4'd8, 4'd1, 4'd10, 4'd3, 4'd12,
        4'd6, 4'd11, 4'd3, 4'd7, 4'd0, 4'd13, 4'd5, 4'd10,
        4'd14, 4'd15, 4'd8, 4'd12, 4'd4, 4'd9, 4'd1, 4'd2,
        4'd15, 4'd5, 4'd1, 4'd3, 4'd7, 4'd14, 4'd6, 4'd9,
        4'd11, 4'd8, 4'd12, 4'd2, 4'd10, 4'd0, 4'd4, 4'd13,
        4'd8, 4'd6, 4'd4, 4'd1, 4'd3, 4'd11, 4'd15, 4'd0,
        4'd5, 4'd12, 4'd2, 4'd13, 4'd9, 4'd7, 4'd10, 4'd14};

    localparam nib_t ROT_L [64] = '{
        4'd11, 4'd14, 4'd15, 4'd12, 4'd5, 4'd8, 4'd7, 4'd9,
        4'd11, 4'd13, 4'd14, 4'd15, 4'd6, 4'd7, 4'd9, 4'd8,
        4'd7, 4'd6, 4'd8, 4'd13, 4'd11, 4'd9, 4'd7, 4'd15,
        4'd7, 4'd12, 4'd15, 4'd9, 4'd11, 4'd7, 4'd13, 4'd12,
        4'd11, 4'd13, 4'd6, 4'd7, 4'd14, 4'd9, 4'd13, 4'd15,
        4'd14, 4'd8, 4'd13, 4'd6, 4'd5, 4'd12, 4'd7, 4'd5,
        4'd11, 4'd12, 4'd14, 4'd15, 4'd14, 4'd15, 4'd9, 4'd8,
        4'd9, 4'd14, 4'd5, 4'd6, 4'd8, 4'd6, 4'd5, 4'd12};

    localparam nib_t ROT_R [64] = '{
        4'd8, 4'd9, 4'd9, 4'd11, 4'd13, 4'd15, 4'd15, 4'd5,
        4'd7, 4'd7, 4'd8, 4'd11, 4'd14, 4'd14, 4'd12, 4'd6,
        4'd9, 4'd13, 4'd15, 4'd7, 4'd12, 4'd8, 4'd9, 4'd11,
        4'd7, 4'd7, 4'd12, 4'd7, 4'd6, 4'd15, 4'd13, 4'd11,
        4'd9, 4'd7, 4'd15, 4'd11, 4'd8, 4'd6, 4'd6, 4'd14,
        4'd12, 4'd13, 4'd5, 4'd14, 4'd13, 4'd13, 4'd7, 4'd5,
        4'd15, 4'd5, 4'd8, 4'd11, 4'd14, 4'd14, 4'd6, 4'd14,
        4'd6, 4'd9, 4'd12, 4'd9, 4'd12, 4'd5, 4'd15, 4'd8};

    localparam logic [31:0] K_L [4] = '{
        32'h00000000, 32'h5a827999, 32'h6ed9eba1, 32'h8f1bbcdc};
    localparam logic [31:0] K_R [4] = '{
        32'h50a28be6, 32'h5c4dd124, 32'h6d703ef3, 32'h00000000};

    localparam logic [31:0] IV [8] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476,
        32'h76543210, 32'hfedcba98, 32'h89abcdef, 32'h01234567};

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LAST_POS = 6'h3F;

endpackage
`default_nettype wire

// ===== hdl/r256_if.sv =====
// Interfaces: message byte channel and digest part channel.
`default_nettype none
interface r256_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last_byte;

    modport source (output valid, data_byte, has_byte, last_byte, input ready);
    modport sink (input valid, data_byte, has_byte, last_byte, output ready);
endinterface

interface r256_digest_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_part;
    logic [1:0]  part_index;
    logic        last_part;

    modport source (output valid, digest_part, part_index, last_part, input ready);
    modport sink (input valid, digest_part, part_index, last_part, output ready);
endinterface
`default_nettype wire

// ===== hdl/r256_ram.sv =====
// Generic RAM: one write port, two registered read ports.
`default_nettype none
module r256_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end
endmodule
`default_nettype wire

// ===== hdl/r256_step.sv =====
// One RIPEMD line step: boolean function, four-term add, left rotate.
`default_nettype none
module r256_step
    import r256_pkg::*;
(
    input  wire step_ctrl_t  ctrl,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    input  wire logic [31:0] c,
    input  wire logic [31:0] d,
    input  wire logic [31:0] m,
    output logic      [31:0] t
);
    logic [31:0] f;
    logic [31:0] sum;
    logic [63:0] dbl;

    always_comb
    begin
        case (ctrl.fsel)
            2'd0:    f = b ^ c ^ d;
            2'd1:    f = (b & c) | (~b & d);
            2'd2:    f = (b | ~c) ^ d;
            default: f = (b & d) | (c & ~d);
        endcase
        sum = a + f + m + ctrl.kadd;
        dbl = {sum, sum} << ctrl.rot;
        t   = dbl[63:32];
    end
endmodule
`default_nettype wire

// ===== hdl/ripemd256_hash_engine.sv =====
// RIPEMD-256 engine: byte packing, padding sequencer, iterative compression.
// The 64th byte of a block starts a compression (1 load + 64 steps, both lines
// together, + 1 chaining add); bytes are taken only while idle.
// A last transaction pads one word per cycle (up to 16), compresses once or
// twice, then offers four digest parts, one per cycle while taken.
// Reset (rst_n low, async) restores the initial chaining words and zero length.
`default_nettype none
module ripemd256_hash_engine
    import r256_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    r256_byte_if.sink  msg,
    r256_digest_if.source digest
);
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_LOAD  = 7'b0000010,
        S_COMP  = 7'b0000100,
        S_FINAL = 7'b0001000,
        S_PADI  = 7'b0010000,
        S_PAD   = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t      state_reg, state_next;
    logic [63:0] total_reg, total_next;
    logic [31:0] word_reg, word_next;
    logic [31:0] cv_reg [8];
    logic [31:0] cv_next [8];
    logic [31:0] l_reg [4];
    logic [31:0] l_next [4];
    logic [31:0] r_reg [4];
    logic [31:0] r_next [4];
    logic [5:0]  step_reg, step_next;
    logic [3:0]  pad_idx_reg, pad_idx_next;
    logic        pad_first_reg, pad_first_next;
    logic        pad_two_reg, pad_two_next;
    logic        pad_final_reg, pad_final_next;
    logic        last_pend_reg, last_pend_next;
    logic [1:0]  part_reg, part_next;

    logic [5:0]  pos;
    logic        accept;
    logic [31:0] ins_word, pad_word, pad_data;
    logic        ram_we;
    logic [3:0]  ram_waddr;
    logic [31:0] ram_wdata;
    logic [5:0]  rd_step;
    logic [31:0] m_l, m_r, t_l, t_r;
    logic [1:0]  rnd;
    step_ctrl_t  ctrl_l, ctrl_r;

    assign pos    = total_reg[5:0];
    assign accept = msg.valid && msg.ready;
    assign msg.ready = (state_reg == S_IDLE);

    assign rnd     = step_reg[5:4];
    assign ctrl_l  = '{fsel: rnd, rot: ROT_L[step_reg], kadd: K_L[rnd]};
    assign ctrl_r  = '{fsel: ~rnd, rot: ROT_R[step_reg], kadd: K_R[rnd]};
    assign rd_step = (state_reg == S_COMP) ? step_reg + 6'd1 : 6'd0;

    r256_ram #(.WIDTH(32), .DEPTH(16)) u_block (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (SEL_L[rd_step]),
        .raddr_b (SEL_R[rd_step]),
        .rdata_a (m_l),
        .rdata_b (m_r)
    );

    r256_step u_step_l (
        .ctrl (ctrl_l), .a (l_reg[0]), .b (l_reg[1]), .c (l_reg[2]), .d (l_reg[3]),
        .m (m_l), .t (t_l)
    );

    r256_step u_step_r (
        .ctrl (ctrl_r), .a (r_reg[0]), .b (r_reg[1]), .c (r_reg[2]), .d (r_reg[3]),
        .m (m_r), .t (t_r)
    );

    always_comb
    begin
        ins_word = word_reg;
        ins_word[8*pos[1:0] +: 8] = msg.data_byte;
        for (int b = 0; b < 4; b++)
        begin
            if (b < int'(pos[1:0]))
                pad_word[8*b +: 8] = word_reg[8*b +: 8];
            else if (b == int'(pos[1:0]))
                pad_word[8*b +: 8] = PAD_BYTE;
            else
                pad_word[8*b +: 8] = 8'h00;
        end
        if (pad_first_reg)
            pad_data = pad_word;
        else if (!pad_two_reg && pad_idx_reg == 4'd14)
            pad_data = {total_reg[28:0], 3'b000};
        else if (!pad_two_reg && pad_idx_reg == 4'd15)
            pad_data = total_reg[60:29];
        else
            pad_data = 32'h0;
    end

    always_comb
    begin
        state_next     = state_reg;
        total_next     = total_reg;
        word_next      = word_reg;
        cv_next        = cv_reg;
        l_next         = l_reg;
        r_next         = r_reg;
        step_next      = step_reg;
        pad_idx_next   = pad_idx_reg;
        pad_first_next = pad_first_reg;
        pad_two_next   = pad_two_reg;
        pad_final_next = pad_final_reg;
        last_pend_next = last_pend_reg;
        part_next      = part_reg;
        ram_we         = 1'b0;
        ram_waddr      = pos[5:2];
        ram_wdata      = ins_word;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (msg.has_byte)
                    begin
                        word_next  = ins_word;
                        total_next = total_reg + 64'd1;
                        ram_we     = (pos[1:0] == 2'd3);
                        if (pos == LAST_POS)
                        begin
                            last_pend_next = msg.last_byte;
                            state_next     = S_LOAD;
                        end
                        else if (msg.last_byte)
                        begin
                            state_next = S_PADI;
                        end
                    end
                    else if (msg.last_byte)
                    begin
                        state_next = S_PADI;
                    end
                end
            end
            S_PADI:
            begin
                pad_idx_next   = pos[5:2];
                pad_first_next = 1'b1;
                pad_two_next   = (pos[5:3] == 3'd7);
                state_next     = S_PAD;
            end
            S_PAD:
            begin
                ram_we         = 1'b1;
                ram_waddr      = pad_idx_reg;
                ram_wdata      = pad_data;
                pad_first_next = 1'b0;
                pad_idx_next   = pad_idx_reg + 4'd1;
                if (pad_idx_reg == 4'd15)
                begin
                    pad_final_next = !pad_two_reg;
                    state_next     = S_LOAD;
                end
            end
            S_LOAD:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    l_next[i] = cv_reg[i];
                    r_next[i] = cv_reg[4+i];
                end
                step_next  = 6'd0;
                state_next = S_COMP;
            end
            S_COMP:
            begin
                l_next[0] = l_reg[3];
                l_next[1] = t_l;
                l_next[2] = l_reg[1];
                l_next[3] = l_reg[2];
                r_next[0] = r_reg[3];
                r_next[1] = t_r;
                r_next[2] = r_reg[1];
                r_next[3] = r_reg[2];
                // end of a round: exchange word j between the lines
                if (step_reg[3:0] == 4'd15)
                begin
                    case (rnd)
                        2'd0:
                        begin
                            l_next[0] = r_reg[3];
                            r_next[0] = l_reg[3];
                        end
                        2'd1:
                        begin
                            l_next[1] = t_r;
                            r_next[1] = t_l;
                        end
                        2'd2:
                        begin
                            l_next[2] = r_reg[1];
                            r_next[2] = l_reg[1];
                        end
                        default:
                        begin
                            l_next[3] = r_reg[2];
                            r_next[3] = l_reg[2];
                        end
                    endcase
                end
                step_next = step_reg + 6'd1;
                if (step_reg == LAST_POS)
                    state_next = S_FINAL;
            end
            S_FINAL:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    cv_next[i]   = cv_reg[i] + l_reg[i];
                    cv_next[4+i] = cv_reg[4+i] + r_reg[i];
                end
                if (pad_final_reg)
                begin
                    part_next  = 2'd0;
                    state_next = S_OUT;
                end
                else if (pad_two_reg)
                begin
                    pad_two_next = 1'b0;
                    pad_idx_next = 4'd0;
                    state_next   = S_PAD;
                end
                else if (last_pend_reg)
                begin
                    last_pend_next = 1'b0;
                    state_next     = S_PADI;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_OUT:
            begin
                if (digest.ready)
                begin
                    part_next = part_reg + 2'd1;
                    if (part_reg == 2'd3)
                    begin
                        cv_next        = IV;
                        total_next     = 64'd0;
                        pad_final_next = 1'b0;
                        state_next     = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            total_reg     <= 64'd0;
            cv_reg        <= IV;
            step_reg      <= 6'd0;
            pad_idx_reg   <= 4'd0;
            pad_first_reg <= 1'b0;
            pad_two_reg   <= 1'b0;
            pad_final_reg <= 1'b0;
            last_pend_reg <= 1'b0;
            part_reg      <= 2'd0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            cv_reg        <= cv_next;
            step_reg      <= step_next;
            pad_idx_reg   <= pad_idx_next;
            pad_first_reg <= pad_first_next;
            pad_two_reg   <= pad_two_next;
            pad_final_reg <= pad_final_next;
            last_pend_reg <= last_pend_next;
            part_reg      <= part_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        l_reg    <= l_next;
        r_reg    <= r_next;
    end

    assign digest.valid       = (state_reg == S_OUT);
    assign digest.digest_part = {cv_reg[{part_reg, 1'b1}], cv_reg[{part_reg, 1'b0}]};
    assign digest.part_index  = part_reg;
    assign digest.last_part   = (part_reg == 2'd3);

`ifndef SYNTHESIS
    a_comp_to_final: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COMP && step_reg == LAST_POS) |=> state_reg == S_FINAL)
        else $error("compression did not finish after 64 steps");
    a_digest_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (digest.valid && digest.ready && digest.last_part) |=>
            (total_reg == 64'd0 && cv_reg[0] == IV[0] && msg.ready))
        else $error("state not restored after digest");
    a_byte_stays_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && msg.has_byte && !msg.last_byte && pos != LAST_POS) |=> msg.ready)
        else $error("mid-block byte stalled the input");
`endif

endmodule
`default_nettype wire
